// File: rtl/core/ec2d_pkg.sv
// Package for the two-dimensional elastic collision pipeline.
// Field widths, internal datapath widths, lane codes and the shared structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ec2d_pkg;

   localparam int PW     = 32;   // position, Q16.16
   localparam int VW     = 24;   // velocity, Q8.16
   localparam int MW     = 16;   // mass, Q8.8
   localparam int DW     = 33;   // position difference
   localparam int DVW    = 25;   // velocity difference
   localparam int MSW    = 17;   // mass sum
   localparam int ADW    = 32;   // |d| per component
   localparam int PRW    = 58;   // dv * d
   localparam int DOTW   = 59;   // dot product
   localparam int SQW    = 65;   // |d|^2
   localparam int ADOTW  = 58;   // |dot|
   localparam int DSPLIT = 33;   // |d|^2 split for mass multiply
   localparam int DLW    = 50;
   localparam int DHW    = 49;
   localparam int DENW   = 82;   // |d|^2 * (ma + mb)
   localparam int ASPLIT = 29;   // |dot| split
   localparam int PPW    = 61;
   localparam int PMW    = 90;   // |d_c| * |dot|
   localparam int CHW    = 30;
   localparam int NCH    = 3;
   localparam int CPW    = 46;
   localparam int NW     = 107;  // dividend
   localparam int QW     = 26;   // quotient
   localparam int RW     = 27;   // unclamped new velocity
   localparam int NLANE  = 4;
   localparam int DIVST  = 26;
   localparam int DIV0   = 8;
   localparam int NST    = DIV0 + DIVST + 2;

   localparam int LANE_AX = 0;
   localparam int LANE_AY = 1;
   localparam int LANE_BX = 2;
   localparam int LANE_BY = 3;

   localparam logic [VW-1:0] VEL_MAX = {1'b0, {(VW-1){1'b1}}};
   localparam logic [VW-1:0] VEL_MIN = {1'b1, {(VW-1){1'b0}}};

   typedef struct packed {
      logic signed [VW-1:0] ax;
      logic signed [VW-1:0] ay;
      logic signed [VW-1:0] bx;
      logic signed [VW-1:0] by;
   } vel_type;

   typedef struct packed {
      vel_type          vel;
      logic [NLANE-1:0] neg;
      logic             coin;
      logic             mz;
      logic [DENW-1:0]  den;
   } side_type;

endpackage

`default_nettype wire

// File: rtl/core/elastic_collision_2d.sv
// Elastic collision of two circular bodies: new velocities from centres,
// velocities and masses. Uses ec2d_pkg.
// Throughput one pair per cycle while the response is not stalled; bubbles close up when it is stalled.
// Four restoring dividers, one quotient bit per stage, set the depth.
// Synchronous reset clears all stage valid bits; datapath registers are not reset.
`timescale 1ns / 1ps
`default_nettype none

module elastic_collision_2d
   import ec2d_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic signed [PW-1:0] req_pos_a_x,
   input  wire logic signed [PW-1:0] req_pos_a_y,
   input  wire logic signed [VW-1:0] req_vel_a_x,
   input  wire logic signed [VW-1:0] req_vel_a_y,
   input  wire logic [MW-1:0]        req_mass_a,
   input  wire logic signed [PW-1:0] req_pos_b_x,
   input  wire logic signed [PW-1:0] req_pos_b_y,
   input  wire logic signed [VW-1:0] req_vel_b_x,
   input  wire logic signed [VW-1:0] req_vel_b_y,
   input  wire logic [MW-1:0]        req_mass_b,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic signed [VW-1:0]      rsp_new_vel_a_x,
   output logic signed [VW-1:0]      rsp_new_vel_a_y,
   output logic signed [VW-1:0]      rsp_new_vel_b_x,
   output logic signed [VW-1:0]      rsp_new_vel_b_y,
   output logic                      rsp_coincident,
   output logic                      rsp_saturated
);

   logic [NST:1] en;
   logic [NST:1] valid_ff, valid_in;

   always_comb begin
      en[NST] = !valid_ff[NST] || !rsp_stall;
      for (int k = NST - 1; k >= 1; k--) begin
         en[k] = !valid_ff[k] || en[k+1];
      end
      valid_in[1] = en[1] ? req_valid : valid_ff[1];
      for (int k = 2; k <= NST; k++) begin
         valid_in[k] = en[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_stall = !en[1];
   assign rsp_valid = valid_ff[NST];

   // stage 1: differences
   logic signed [DW-1:0]  dx_ff, dy_ff, dx_in, dy_in;
   logic signed [DVW-1:0] dvx_ff, dvy_ff, dvx_in, dvy_in;
   logic [MSW-1:0]        msum_ff, msum_in;
   logic [MW-1:0]         ma_s1_ff, mb_s1_ff;
   vel_type               vel_s1_ff, vel_s1_in;

   always_comb begin
      dx_in      = {req_pos_a_x[PW-1], req_pos_a_x} - {req_pos_b_x[PW-1], req_pos_b_x};
      dy_in      = {req_pos_a_y[PW-1], req_pos_a_y} - {req_pos_b_y[PW-1], req_pos_b_y};
      dvx_in     = {req_vel_a_x[VW-1], req_vel_a_x} - {req_vel_b_x[VW-1], req_vel_b_x};
      dvy_in     = {req_vel_a_y[VW-1], req_vel_a_y} - {req_vel_b_y[VW-1], req_vel_b_y};
      msum_in    = {1'b0, req_mass_a} + {1'b0, req_mass_b};
      vel_s1_in.ax = req_vel_a_x;
      vel_s1_in.ay = req_vel_a_y;
      vel_s1_in.bx = req_vel_b_x;
      vel_s1_in.by = req_vel_b_y;
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         dx_ff     <= dx_in;
         dy_ff     <= dy_in;
         dvx_ff    <= dvx_in;
         dvy_ff    <= dvy_in;
         msum_ff   <= msum_in;
         ma_s1_ff  <= req_mass_a;
         mb_s1_ff  <= req_mass_b;
         vel_s1_ff <= vel_s1_in;
      end
   end

   // stage 2: products, magnitudes
   logic signed [PRW-1:0]  pdx_ff, pdy_ff, pdx_in, pdy_in;
   logic signed [2*DW-1:0] sqx_full, sqy_full;
   logic [SQW-1:0]         sqx_ff, sqy_ff;
   logic [ADW-1:0]         adx_s2_ff, ady_s2_ff, adx_in, ady_in;
   logic                   negx_s2_ff, negy_s2_ff, coin_s2_ff, mz_s2_ff;
   logic [MSW-1:0]         msum_s2_ff;
   logic [MW-1:0]          ma_s2_ff, mb_s2_ff;
   vel_type                vel_s2_ff;

   always_comb begin
      pdx_in   = dvx_ff * dx_ff;
      pdy_in   = dvy_ff * dy_ff;
      sqx_full = dx_ff * dx_ff;
      sqy_full = dy_ff * dy_ff;
      adx_in   = dx_ff[DW-1] ? ADW'(-dx_ff) : ADW'(dx_ff);
      ady_in   = dy_ff[DW-1] ? ADW'(-dy_ff) : ADW'(dy_ff);
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         pdx_ff     <= pdx_in;
         pdy_ff     <= pdy_in;
         sqx_ff     <= sqx_full[SQW-1:0];
         sqy_ff     <= sqy_full[SQW-1:0];
         adx_s2_ff  <= adx_in;
         ady_s2_ff  <= ady_in;
         negx_s2_ff <= dx_ff[DW-1];
         negy_s2_ff <= dy_ff[DW-1];
         coin_s2_ff <= (dx_ff == '0) && (dy_ff == '0);
         mz_s2_ff   <= (msum_ff == '0);
         msum_s2_ff <= msum_ff;
         ma_s2_ff   <= ma_s1_ff;
         mb_s2_ff   <= mb_s1_ff;
         vel_s2_ff  <= vel_s1_ff;
      end
   end

   // stage 3: dot product and |d|^2
   logic signed [DOTW-1:0] dot_ff, dot_in;
   logic [SQW-1:0]         d2_ff, d2_in;
   logic [ADW-1:0]         adx_s3_ff, ady_s3_ff;
   logic                   negx_s3_ff, negy_s3_ff, coin_s3_ff, mz_s3_ff;
   logic [MSW-1:0]         msum_s3_ff;
   logic [MW-1:0]          ma_s3_ff, mb_s3_ff;
   vel_type                vel_s3_ff;

   always_comb begin
      dot_in = DOTW'(pdx_ff) + DOTW'(pdy_ff);
      d2_in  = sqx_ff + sqy_ff;
   end

   always_ff @(posedge clock) begin
      if (en[3]) begin
         dot_ff     <= dot_in;
         d2_ff      <= d2_in;
         adx_s3_ff  <= adx_s2_ff;
         ady_s3_ff  <= ady_s2_ff;
         negx_s3_ff <= negx_s2_ff;
         negy_s3_ff <= negy_s2_ff;
         coin_s3_ff <= coin_s2_ff;
         mz_s3_ff   <= mz_s2_ff;
         msum_s3_ff <= msum_s2_ff;
         ma_s3_ff   <= ma_s2_ff;
         mb_s3_ff   <= mb_s2_ff;
         vel_s3_ff  <= vel_s2_ff;
      end
   end

   // stage 4: |dot|, denominator partials
   logic [ADOTW-1:0] adot_ff, adot_in;
   logic [DLW-1:0]   denlo_ff, denlo_in;
   logic [DHW-1:0]   denhi_ff, denhi_in;
   logic [ADW-1:0]   adx_s4_ff, ady_s4_ff;
   logic             negx_s4_ff, negy_s4_ff, negdot_ff, coin_s4_ff, mz_s4_ff;
   logic [MW-1:0]    ma_s4_ff, mb_s4_ff;
   vel_type          vel_s4_ff;

   always_comb begin
      adot_in  = dot_ff[DOTW-1] ? ADOTW'(-dot_ff) : ADOTW'(dot_ff);
      denlo_in = DLW'(d2_ff[DSPLIT-1:0]) * DLW'(msum_s3_ff);
      denhi_in = DHW'(d2_ff[SQW-1:DSPLIT]) * DHW'(msum_s3_ff);
   end

   always_ff @(posedge clock) begin
      if (en[4]) begin
         adot_ff    <= adot_in;
         denlo_ff   <= denlo_in;
         denhi_ff   <= denhi_in;
         adx_s4_ff  <= adx_s3_ff;
         ady_s4_ff  <= ady_s3_ff;
         negx_s4_ff <= negx_s3_ff;
         negy_s4_ff <= negy_s3_ff;
         negdot_ff  <= dot_ff[DOTW-1];
         coin_s4_ff <= coin_s3_ff;
         mz_s4_ff   <= mz_s3_ff;
         ma_s4_ff   <= ma_s3_ff;
         mb_s4_ff   <= mb_s3_ff;
         vel_s4_ff  <= vel_s3_ff;
      end
   end

   // stage 5: denominator, |d_c| * |dot| partials
   logic [DENW-1:0]  den_s5_ff, den_in;
   logic [PPW-1:0]   pxl_ff, pxh_ff, pyl_ff, pyh_ff;
   logic [PPW-1:0]   pxl_in, pxh_in, pyl_in, pyh_in;
   logic [NLANE-1:0] neg_s5_ff, neg_in;
   logic             coin_s5_ff, mz_s5_ff;
   logic [MW-1:0]    ma_s5_ff, mb_s5_ff;
   vel_type          vel_s5_ff;

   always_comb begin
      den_in = DENW'(denlo_ff) + (DENW'(denhi_ff) << DSPLIT);
      pxl_in = PPW'(adx_s4_ff) * PPW'(adot_ff[ASPLIT-1:0]);
      pxh_in = PPW'(adx_s4_ff) * PPW'(adot_ff[ADOTW-1:ASPLIT]);
      pyl_in = PPW'(ady_s4_ff) * PPW'(adot_ff[ASPLIT-1:0]);
      pyh_in = PPW'(ady_s4_ff) * PPW'(adot_ff[ADOTW-1:ASPLIT]);
      neg_in[LANE_AX] = negx_s4_ff ^ negdot_ff;
      neg_in[LANE_AY] = negy_s4_ff ^ negdot_ff;
      neg_in[LANE_BX] = negx_s4_ff ^ negdot_ff;
      neg_in[LANE_BY] = negy_s4_ff ^ negdot_ff;
   end

   always_ff @(posedge clock) begin
      if (en[5]) begin
         den_s5_ff  <= den_in;
         pxl_ff     <= pxl_in;
         pxh_ff     <= pxh_in;
         pyl_ff     <= pyl_in;
         pyh_ff     <= pyh_in;
         neg_s5_ff  <= neg_in;
         coin_s5_ff <= coin_s4_ff;
         mz_s5_ff   <= mz_s4_ff;
         ma_s5_ff   <= ma_s4_ff;
         mb_s5_ff   <= mb_s4_ff;
         vel_s5_ff  <= vel_s4_ff;
      end
   end

   // stage 6: |d_c| * |dot|
   logic [PMW-1:0]   px_ff, py_ff, px_in, py_in;
   logic [DENW-1:0]  den_s6_ff;
   logic [NLANE-1:0] neg_s6_ff;
   logic             coin_s6_ff, mz_s6_ff;
   logic [MW-1:0]    ma_s6_ff, mb_s6_ff;
   vel_type          vel_s6_ff;

   always_comb begin
      px_in = PMW'(pxl_ff) + (PMW'(pxh_ff) << ASPLIT);
      py_in = PMW'(pyl_ff) + (PMW'(pyh_ff) << ASPLIT);
   end

   always_ff @(posedge clock) begin
      if (en[6]) begin
         px_ff      <= px_in;
         py_ff      <= py_in;
         den_s6_ff  <= den_s5_ff;
         neg_s6_ff  <= neg_s5_ff;
         coin_s6_ff <= coin_s5_ff;
         mz_s6_ff   <= mz_s5_ff;
         ma_s6_ff   <= ma_s5_ff;
         mb_s6_ff   <= mb_s5_ff;
         vel_s6_ff  <= vel_s5_ff;
      end
   end

   // stage 7: mass partial products per lane
   logic [CPW-1:0]   prod_ff [NLANE][NCH];
   logic [CPW-1:0]   prod_in [NLANE][NCH];
   logic [DENW-1:0]  den_s7_ff;
   logic [NLANE-1:0] neg_s7_ff;
   logic             coin_s7_ff, mz_s7_ff;
   vel_type          vel_s7_ff;

   always_comb begin
      logic [PMW-1:0] psel;
      logic [MW-1:0]  msel;
      for (int l = 0; l < NLANE; l++) begin
         psel = (l == LANE_AX || l == LANE_BX) ? px_ff : py_ff;
         msel = (l == LANE_AX || l == LANE_AY) ? mb_s6_ff : ma_s6_ff;
         for (int j = 0; j < NCH; j++) begin
            prod_in[l][j] = CPW'(psel[j*CHW +: CHW]) * CPW'(msel);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[7]) begin
         prod_ff    <= prod_in;
         den_s7_ff  <= den_s6_ff;
         neg_s7_ff  <= neg_s6_ff;
         coin_s7_ff <= coin_s6_ff;
         mz_s7_ff   <= mz_s6_ff;
         vel_s7_ff  <= vel_s6_ff;
      end
   end

   // stage 8 onward: dividend, then one quotient bit per stage
   logic [NW-1:0] rem_ff [DIVST+1][NLANE];
   logic [QW-1:0] q_ff   [DIVST+1][NLANE];
   side_type      side_ff [DIVST+1];
   logic [NW-1:0] num_in [NLANE];

   always_comb begin
      for (int l = 0; l < NLANE; l++) begin
         num_in[l] = (NW'(prod_ff[l][0]) + (NW'(prod_ff[l][1]) << CHW)
                      + (NW'(prod_ff[l][2]) << (2*CHW))) << 1;
      end
   end

   always_ff @(posedge clock) begin
      if (en[DIV0]) begin
         for (int l = 0; l < NLANE; l++) begin
            rem_ff[0][l] <= num_in[l];
            q_ff[0][l]   <= '0;
         end
         side_ff[0].vel  <= vel_s7_ff;
         side_ff[0].neg  <= neg_s7_ff;
         side_ff[0].coin <= coin_s7_ff;
         side_ff[0].mz   <= mz_s7_ff;
         side_ff[0].den  <= den_s7_ff;
      end
   end

   for (genvar gk = 0; gk < DIVST; gk++) begin : g_div
      for (genvar gl = 0; gl < NLANE; gl++) begin : g_lane
         logic [NW-1:0] dsh;
         logic          take;
         logic [NW-1:0] rem_in;
         logic [QW-1:0] q_in;

         assign dsh    = NW'(side_ff[gk].den) << (QW - 1 - gk);
         assign take   = rem_ff[gk][gl] >= dsh;
         assign rem_in = take ? rem_ff[gk][gl] - dsh : rem_ff[gk][gl];
         assign q_in   = q_ff[gk][gl] | (take ? (QW'(1) << (QW - 1 - gk)) : '0);

         always_ff @(posedge clock) begin
            if (en[DIV0+1+gk]) begin
               rem_ff[gk+1][gl] <= rem_in;
               q_ff[gk+1][gl]   <= q_in;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (en[DIV0+1+gk]) begin
            side_ff[gk+1] <= side_ff[gk];
         end
      end
   end

   // rounding: half up on magnitude, so ties go away from zero
   logic [QW-1:0] mag_ff [NLANE];
   logic [QW-1:0] mag_in [NLANE];
   side_type      side_r_ff;

   always_comb begin
      for (int l = 0; l < NLANE; l++) begin
         mag_in[l] = q_ff[DIVST][l]
                   + QW'({rem_ff[DIVST][l][DENW-1:0], 1'b0} >= {1'b0, side_ff[DIVST].den});
      end
   end

   always_ff @(posedge clock) begin
      if (en[NST-1]) begin
         mag_ff    <= mag_in;
         side_r_ff <= side_ff[DIVST];
      end
   end

   // output: apply correction and clamp, or pass velocities through for coincident or zero-mass-sum pairs
   logic signed [VW-1:0] res_in [NLANE];
   logic [NLANE-1:0]     satl_in;
   logic signed [VW-1:0] rsp_new_vel_a_x_ff, rsp_new_vel_a_y_ff;
   logic signed [VW-1:0] rsp_new_vel_b_x_ff, rsp_new_vel_b_y_ff;
   logic                 rsp_coincident_ff, rsp_saturated_ff;
   logic                 pass_in;

   always_comb begin
      logic signed [VW-1:0] vsel;
      logic signed [RW-1:0] cs;
      logic signed [RW-1:0] r;
      logic                 fits;
      pass_in = side_r_ff.coin || side_r_ff.mz;
      for (int l = 0; l < NLANE; l++) begin
         case (l)
            LANE_AX: vsel = side_r_ff.vel.ax;
            LANE_AY: vsel = side_r_ff.vel.ay;
            LANE_BX: vsel = side_r_ff.vel.bx;
            default: vsel = side_r_ff.vel.by;
         endcase
         cs   = side_r_ff.neg[l] ? -RW'(mag_ff[l]) : RW'(mag_ff[l]);
         r    = (l == LANE_AX || l == LANE_AY) ? RW'(vsel) - cs : RW'(vsel) + cs;
         fits = (&r[RW-1:VW-1]) || !(|r[RW-1:VW-1]);
         if (pass_in) begin
            res_in[l]  = vsel;
            satl_in[l] = 1'b0;
         end else if (fits) begin
            res_in[l]  = r[VW-1:0];
            satl_in[l] = 1'b0;
         end else begin
            res_in[l]  = r[RW-1] ? VEL_MIN : VEL_MAX;
            satl_in[l] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[NST]) begin
         rsp_new_vel_a_x_ff <= res_in[LANE_AX];
         rsp_new_vel_a_y_ff <= res_in[LANE_AY];
         rsp_new_vel_b_x_ff <= res_in[LANE_BX];
         rsp_new_vel_b_y_ff <= res_in[LANE_BY];
         rsp_coincident_ff  <= side_r_ff.coin;
         rsp_saturated_ff   <= |satl_in;
      end
   end

   assign rsp_new_vel_a_x = rsp_new_vel_a_x_ff;
   assign rsp_new_vel_a_y = rsp_new_vel_a_y_ff;
   assign rsp_new_vel_b_x = rsp_new_vel_b_x_ff;
   assign rsp_new_vel_b_y = rsp_new_vel_b_y_ff;
   assign rsp_coincident  = rsp_coincident_ff;
   assign rsp_saturated   = rsp_saturated_ff;

endmodule

`default_nettype wire

// File: rtl/core/ec2d_check.sv
// Port-level checks for elastic_collision_2d, attached by bind.
// Uses ec2d_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

module ec2d_check
   import ec2d_pkg::*;
(
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 rsp_valid,
   input wire logic                 rsp_stall,
   input wire logic signed [VW-1:0] rsp_new_vel_a_x,
   input wire logic                 rsp_coincident,
   input wire logic                 rsp_saturated
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_new_vel_a_x))
      else $error("stalled response beat changed");

   a_coin_nosat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_coincident |-> !rsp_saturated)
      else $error("coincident beat flagged saturated");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid straight after reset");

endmodule

bind elastic_collision_2d ec2d_check u_ec2d_check (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_new_vel_a_x (rsp_new_vel_a_x),
   .rsp_coincident  (rsp_coincident),
   .rsp_saturated   (rsp_saturated)
);

`default_nettype wire

// File: tb/tb_top.sv
// Self-checking bench for elastic_collision_2d: directed and random body pairs,
// bursty sender, patterned receiver stalls, scoreboard against a local predictor.
// Depends on ec2d_pkg and the elastic_collision_2d RTL.
`timescale 1ns / 1ps

module tb_top;
   import ec2d_pkg::*;

   typedef struct {
      logic signed [PW-1:0] pax, pay, pbx, pby;
      logic signed [VW-1:0] vax, vay, vbx, vby;
      logic [MW-1:0]        ma, mb;
   } pair_type;

   typedef struct {
      logic signed [VW-1:0] ax, ay, bx, by;
      logic                 coin, sat;
   } bounce_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [VW-1:0] rsp_ax, rsp_ay, rsp_bx, rsp_by;
   logic rsp_coin, rsp_sat;
   pair_type cur = '{default: '0};

   pair_type   pending[$];
   bounce_type awaited[$];
   int n_sent = 0, n_recv = 0, n_bad = 0, n_coin = 0, n_sat = 0;
   int burst_left = 0, gap_left = 0, hold_left = 0, cyc = 0;
   bit held = 0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   elastic_collision_2d dut (
      .clock, .reset, .req_valid, .req_stall,
      .req_pos_a_x(cur.pax), .req_pos_a_y(cur.pay),
      .req_vel_a_x(cur.vax), .req_vel_a_y(cur.vay), .req_mass_a(cur.ma),
      .req_pos_b_x(cur.pbx), .req_pos_b_y(cur.pby),
      .req_vel_b_x(cur.vbx), .req_vel_b_y(cur.vby), .req_mass_b(cur.mb),
      .rsp_valid, .rsp_stall,
      .rsp_new_vel_a_x(rsp_ax), .rsp_new_vel_a_y(rsp_ay),
      .rsp_new_vel_b_x(rsp_bx), .rsp_new_vel_b_y(rsp_by),
      .rsp_coincident(rsp_coin), .rsp_saturated(rsp_sat)
   );

   // d_c * dot * twom / den, nearest, ties away from zero
   function automatic longint impulse(longint dc, longint dot, logic [127:0] twom,
                                      logic [127:0] den);
      logic [127:0] num, q, r;
      num = 128'(dc < 0 ? -dc : dc) * twom * 128'(dot < 0 ? -dot : dot);
      q = num / den;
      r = num % den;
      if ((r << 1) >= den) q = q + 1;
      return ((dc < 0) != (dot < 0)) ? -longint'(q) : longint'(q);
   endfunction

   function automatic logic signed [VW-1:0] clip(longint v, inout logic sat);
      if (v > 64'sd8388607) begin
         sat = 1'b1;
         return VEL_MAX;
      end
      if (v < -64'sd8388608) begin
         sat = 1'b1;
         return VEL_MIN;
      end
      return VW'(v);
   endfunction

   function automatic bounce_type collide(pair_type p);
      bounce_type o;
      longint dx, dy, dot;
      logic [127:0] ax, ay, den, msum;
      dx = longint'(p.pax) - longint'(p.pbx);
      dy = longint'(p.pay) - longint'(p.pby);
      o = '{ax: p.vax, ay: p.vay, bx: p.vbx, by: p.vby, coin: 1'b0, sat: 1'b0};
      msum = 128'(p.ma) + 128'(p.mb);
      if (dx == 0 && dy == 0) begin
         o.coin = 1'b1;
      end else if (msum != 0) begin
         dot = (longint'(p.vax) - longint'(p.vbx)) * dx
             + (longint'(p.vay) - longint'(p.vby)) * dy;
         ax = 128'(dx < 0 ? -dx : dx);
         ay = 128'(dy < 0 ? -dy : dy);
         den = (ax * ax + ay * ay) * msum;
         o.ax = clip(longint'(p.vax) - impulse(dx, dot, 2 * 128'(p.mb), den), o.sat);
         o.ay = clip(longint'(p.vay) - impulse(dy, dot, 2 * 128'(p.mb), den), o.sat);
         o.bx = clip(longint'(p.vbx) + impulse(dx, dot, 2 * 128'(p.ma), den), o.sat);
         o.by = clip(longint'(p.vby) + impulse(dy, dot, 2 * 128'(p.ma), den), o.sat);
      end
      return o;
   endfunction

   function automatic pair_type mk(int pax, int pay, int vax, int vay, int ma,
                                   int pbx, int pby, int vbx, int vby, int mb);
      pair_type p;
      p = '{pax: PW'(pax), pay: PW'(pay), vax: VW'(vax), vay: VW'(vay), ma: MW'(ma),
            pbx: PW'(pbx), pby: PW'(pby), vbx: VW'(vbx), vby: VW'(vby), mb: MW'(mb)};
      return p;
   endfunction

   function automatic logic [VW-1:0] rand_vel(bit wide);
      return wide ? VW'($urandom) : VW'($urandom_range(0, 262143) - 131072);
   endfunction

   function automatic pair_type rand_pair();
      pair_type p;
      int unsigned sel;
      sel = $urandom_range(0, 99);
      p.pax = $urandom;
      p.pay = $urandom;
      if (sel < 70) begin
         // nearby bodies, the usual contact case
         p.pbx = p.pax - PW'($urandom_range(0, 4194304) - 2097152);
         p.pby = p.pay - PW'($urandom_range(0, 4194304) - 2097152);
      end else if (sel < 75) begin
         p.pbx = p.pax;
         p.pby = p.pay;
      end else begin
         p.pbx = $urandom;
         p.pby = $urandom;
      end
      p.vax = rand_vel(sel % 4 == 0);
      p.vay = rand_vel(sel % 4 == 0);
      p.vbx = rand_vel(sel % 3 == 0);
      p.vby = rand_vel(sel % 3 == 0);
      p.ma = ($urandom_range(0, 1)) ? MW'($urandom_range(1, 65535)) : MW'($urandom_range(64, 1024));
      p.mb = ($urandom_range(0, 1)) ? MW'($urandom_range(1, 65535)) : MW'($urandom_range(64, 1024));
      if (sel == 99) p.ma = '0;
      return p;
   endfunction

   // sender: bursts with gaps; valid is held while stalled
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            awaited.push_back(collide(cur));
            n_sent++;
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending.size() > 0) begin
               cur <= pending.pop_front();
               req_valid <= 1'b1;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(0, 40);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver stall pattern, with one long hold-off to back the pipe up
   always @(posedge clock) begin
      cyc++;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (!held && n_sent >= 300) begin
         held = 1;
         hold_left = 250;
         rsp_stall <= 1'b1;
      end else begin
         case ((cyc / 500) % 4)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 9) < 3);
            2: rsp_stall <= (cyc % 7 < 2);
            default: rsp_stall <= ($urandom_range(0, 9) < 7);
         endcase
      end
   end

   always @(posedge clock) begin
      bounce_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         n_recv++;
         if (awaited.size() == 0) begin
            n_bad++;
            if (n_bad <= 10) $display("unexpected response beat %0d", n_recv);
         end else begin
            e = awaited.pop_front();
            n_coin += int'(e.coin);
            n_sat += int'(e.sat);
            if (rsp_ax !== e.ax || rsp_ay !== e.ay || rsp_bx !== e.bx || rsp_by !== e.by
                || rsp_coin !== e.coin || rsp_sat !== e.sat) begin
               n_bad++;
               if (n_bad <= 10)
                  $display("beat %0d: exp %0d %0d %0d %0d c%b s%b got %0d %0d %0d %0d c%b s%b",
                           n_recv, e.ax, e.ay, e.bx, e.by, e.coin, e.sat,
                           rsp_ax, rsp_ay, rsp_bx, rsp_by, rsp_coin, rsp_sat);
            end
         end
      end
   end

   initial begin
      // coincident, zero masses, head-on, glancing, field extremes
      pending.push_back(mk(0, 0, 65536, 0, 256, 0, 0, -65536, 0, 256));
      pending.push_back(mk(-2147483647 - 1, 2147483647, 8388607, -8388608, 65535,
                           -2147483647 - 1, 2147483647, -8388608, 8388607, 1));
      pending.push_back(mk(0, 0, 65536, 0, 0, 65536, 0, -65536, 0, 0));
      pending.push_back(mk(0, 0, 65536, 0, 0, 65536, 0, -65536, 0, 256));
      pending.push_back(mk(0, 0, 65536, 0, 256, 65536, 0, -65536, 0, 0));
      pending.push_back(mk(0, 0, 65536, 0, 256, 65536, 0, -65536, 0, 256));
      pending.push_back(mk(0, 0, 65536, 32768, 512, 65536, 65536, 0, 0, 256));
      pending.push_back(mk(2147483647, 2147483647, 8388607, 8388607, 65535,
                           -2147483647 - 1, -2147483647 - 1, -8388608, -8388608, 65535));
      pending.push_back(mk(-2147483647 - 1, 0, 8388607, 0, 1, 2147483647, 0,
                           -8388608, 0, 65535));
      pending.push_back(mk(0, 0, 8388607, 8388607, 1, 1, 1, -8388608, -8388608, 65535));
      pending.push_back(mk(0, 0, -8388608, 0, 65535, -1, 0, 8388607, 0, 1));
      pending.push_back(mk(0, 0, 1, -1, 1, 0, 1, 0, 0, 1));
      pending.push_back(mk(0, 0, 3, 0, 1, 2, 0, 0, 0, 1));
      pending.push_back(mk(100, -100, 0, 0, 300, 0, 0, 0, 0, 300));
      pending.push_back(mk(0, 0, 65536, 0, 256, 0, 65536, 0, 0, 256));
      pending.push_back(mk(-65536, 0, 0, 0, 65535, 0, 0, -8388608, 0, 65535));
      repeat (1400) pending.push_back(rand_pair());
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      wait (pending.size() == 0 && !req_valid && awaited.size() == 0);
      repeat (60) @(posedge clock);
      $display("%0d pairs driven, %0d responses checked (%0d coincident, %0d clamped)",
               n_sent, n_recv, n_coin, n_sat);
      if (n_bad == 0 && awaited.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   initial begin
      #3000000;
      $display("timeout with %0d beats outstanding", awaited.size());
      $display("simulation failed");
      $finish;
   end

endmodule
